[hw/rtl/i32alu_pkg.sv]
// ----------------------------------------------------------------------------
// i32alu_pkg - shared types and constants for the 32-bit integer ALU
// Operation codes, word width and the per-stage record of the divide chain.
// ----------------------------------------------------------------------------
package i32alu_pkg;

  localparam int unsigned Width = 32;
  localparam int unsigned OpWidth = 4;

  typedef enum logic [OpWidth-1:0] {
    OP_NEG = 4'd0,
    OP_ADD = 4'd1,
    OP_SUB = 4'd2,
    OP_MUL = 4'd3,
    OP_DIV = 4'd4,
    OP_MOD = 4'd5,
    OP_AND = 4'd6,
    OP_OR  = 4'd7,
    OP_XOR = 4'd8,
    OP_LSL = 4'd9,
    OP_ASR = 4'd10,
    OP_LSR = 4'd11,
    OP_CMP = 4'd12
  } op_e;

  // Record carried by each cell of the pipeline
  typedef struct packed {
    logic             valid;
    logic [OpWidth-1:0] op;
    logic [Width-1:0] rem;      // partial remainder
    logic [Width-1:0] quo;      // dividend bits shifting out / quotient in
    logic [Width-1:0] dvs;      // divisor magnitude
    logic             neg_q;    // quotient negative
    logic             neg_r;    // remainder negative
    logic             dz;       // divide by zero
    logic [Width-1:0] res;      // result of non-divide ops
  } cell_t;

endpackage

[hw/rtl/i32alu_cell.sv]
// ----------------------------------------------------------------------------
// i32alu_cell - one restoring-division step cell
// Takes one quotient bit per cycle and hands the record to the next cell.
// ----------------------------------------------------------------------------
module i32alu_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  i32alu_pkg::cell_t  cell_i,
  output i32alu_pkg::cell_t  cell_o
);

  i32alu_pkg::cell_t cell_d, cell_q;
  logic valid_q;
  logic [i32alu_pkg::Width:0] trial;
  logic [i32alu_pkg::Width:0] shifted;

  // One divide step: shift in next dividend bit, trial subtract
  always_comb begin
    cell_d  = cell_i;
    shifted = {cell_i.rem, cell_i.quo[i32alu_pkg::Width-1]};
    trial   = shifted - {1'b0, cell_i.dvs};
    if (!trial[i32alu_pkg::Width]) begin
      cell_d.rem = trial[i32alu_pkg::Width-1:0];
      cell_d.quo = {cell_i.quo[i32alu_pkg::Width-2:0], 1'b1};
    end else begin
      cell_d.rem = shifted[i32alu_pkg::Width-1:0];
      cell_d.quo = {cell_i.quo[i32alu_pkg::Width-2:0], 1'b0};
    end
  end

  // Valid flag, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_d.valid;
    end
  end

  // Datapath record, no reset
  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_comb begin
    cell_o       = cell_q;
    cell_o.valid = valid_q;
  end

endmodule

[hw/rtl/int32_alu.sv]
// ----------------------------------------------------------------------------
// int32_alu - 32-bit two's-complement integer ALU
// Negate, add, subtract, multiply, divide, remainder, logic, shifts, compare.
// ----------------------------------------------------------------------------
// Usage:
//   Drive op_i, operand_a_i and operand_b_i with start_i high; the item is
//   taken on any edge where busy_o is low. busy_o is always low: one item
//   is accepted every cycle.
//   Every item gives one result on result_value_o / divide_error_o, shown
//   for one cycle with done_o high, in the order items were accepted.
//   Every op takes the same path: one input register, a row of 32
//   division cells (one quotient bit each), and an output register that
//   applies signs. Non-divide results are computed at entry and ride
//   along the row. The multiplier is split into 16-bit partial products
//   across the input stage and the first cell stage boundary.
//   Reset clears all valid flags; no result appears until items arrive.
//   The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module int32_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  op_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic        done_o,
  output logic signed [31:0] result_value_o,
  output logic        divide_error_o
);

  localparam int unsigned W = i32alu_pkg::Width;

  i32alu_pkg::cell_t head_d, head_q;
  logic head_valid_q;
  i32alu_pkg::cell_t chain [W+1];
  logic [W-1:0] a, b, ma, mb, res_d;
  logic [4:0]   sh;
  logic [W-1:0] pp_ll, pp_lh, pp_hl;
  logic [W-1:0] mul_q;

  assign busy_o = 1'b0;
  assign a  = operand_a_i;
  assign b  = operand_b_i;
  assign sh = b[4:0];
  assign ma = a[W-1] ? (~a + 1'b1) : a;
  assign mb = b[W-1] ? (~b + 1'b1) : b;

  // 16x16 partial products of the low word
  assign pp_ll = a[15:0] * b[15:0];
  assign pp_lh = a[15:0] * b[31:16];
  assign pp_hl = a[31:16] * b[15:0];

  // Non-divide results
  always_comb begin
    res_d = '0;
    case (op_i)
      i32alu_pkg::OP_NEG: res_d = ~a + 1'b1;
      i32alu_pkg::OP_ADD: res_d = a + b;
      i32alu_pkg::OP_SUB: res_d = a - b;
      i32alu_pkg::OP_AND: res_d = a & b;
      i32alu_pkg::OP_OR:  res_d = a | b;
      i32alu_pkg::OP_XOR: res_d = a ^ b;
      i32alu_pkg::OP_LSL: res_d = a << sh;
      i32alu_pkg::OP_ASR: res_d = $unsigned(operand_a_i >>> sh);
      i32alu_pkg::OP_LSR: res_d = a >> sh;
      i32alu_pkg::OP_CMP: begin
        if (operand_a_i < operand_b_i) res_d = '1;
        else if (operand_a_i > operand_b_i) res_d = 32'd1;
        else res_d = '0;
      end
      default: res_d = '0;
    endcase
  end

  // Head record of the chain; multiply carries its low partial product
  always_comb begin
    head_d.valid = start_i;
    head_d.op    = op_i;
    head_d.rem   = '0;
    head_d.quo   = ma;
    head_d.dvs   = mb;
    head_d.neg_q = a[W-1] ^ b[W-1];
    head_d.neg_r = a[W-1];
    head_d.dz    = (b == '0);
    head_d.res   = (op_i == i32alu_pkg::OP_MUL) ? pp_ll : res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    mul_q  <= pp_lh + pp_hl;
  end

  // Finish the product on the first cell's input
  always_comb begin
    chain[0] = head_q;
    chain[0].valid = head_valid_q;
    if (head_q.op == i32alu_pkg::OP_MUL) begin
      chain[0].res = head_q.res + {mul_q[15:0], 16'd0};
    end
  end

  // Row of division cells
  for (genvar i = 0; i < W; i++) begin : g_cell
    i32alu_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  // Output stage: sign fixup and select
  i32alu_pkg::cell_t tail;
  logic        done_d, done_q, err_d, err_q;
  logic [W-1:0] val_d, val_q;

  assign tail = chain[W];

  always_comb begin
    done_d = tail.valid;
    err_d  = 1'b0;
    val_d  = tail.res;
    if (tail.op == i32alu_pkg::OP_DIV || tail.op == i32alu_pkg::OP_MOD) begin
      if (tail.dz) begin
        err_d = 1'b1;
        val_d = '0;
      end else if (tail.op == i32alu_pkg::OP_DIV) begin
        val_d = tail.neg_q ? (~tail.quo + 1'b1) : tail.quo;
      end else begin
        val_d = tail.neg_r ? (~tail.rem + 1'b1) : tail.rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= err_d;
    val_q <= val_d;
  end

  assign done_o         = done_q;
  assign divide_error_o = err_q;
  assign result_value_o = val_q;

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb - self-checking testbench for int32_alu
// Directed corner items, then random items across idle phases. A predictor
// computes each expected result at acceptance; the monitor compares results
// in order as they come out.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_item_t;

  typedef struct {
    logic [31:0] value;
    logic        dz;
  } alu_result_t;

  localparam int unsigned Latency = 34;
  localparam int unsigned NumRandom = 900;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [3:0]  op_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic        done_o;
  logic signed [31:0] result_value_o;
  logic        divide_error_o;

  alu_item_t   item_q[$];
  alu_result_t expected_q[$];
  int unsigned idle_pct = 0;
  int unsigned num_errors = 0;
  int unsigned num_checked = 0;
  int unsigned num_dz = 0;
  bit          hold_until_drained = 1'b0;
  bit          stim_done = 1'b0;

  always #5 clk_i = ~clk_i;

  int32_alu i_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .op_i,
    .operand_a_i,
    .operand_b_i,
    .done_o,
    .result_value_o,
    .divide_error_o
  );

  // Expected result of one item
  function automatic alu_result_t alu_predict(alu_item_t it);
    alu_result_t r;
    logic [31:0] ma, mb, q, rm;
    logic [63:0] prod;
    logic [4:0]  sh;
    r.value = '0;
    r.dz = 1'b0;
    sh = it.b[4:0];
    ma = it.a[31] ? -it.a : it.a;
    mb = it.b[31] ? -it.b : it.b;
    case (it.op) inside
      i32alu_pkg::OP_NEG: r.value = -it.a;
      i32alu_pkg::OP_ADD: r.value = it.a + it.b;
      i32alu_pkg::OP_SUB: r.value = it.a - it.b;
      i32alu_pkg::OP_MUL: begin
        prod = {32'd0, it.a} * {32'd0, it.b};
        r.value = prod[31:0];
      end
      i32alu_pkg::OP_DIV, i32alu_pkg::OP_MOD: begin
        if (it.b == '0) begin
          r.dz = 1'b1;
        end else if (it.op == i32alu_pkg::OP_DIV) begin
          q = ma / mb;
          r.value = (it.a[31] ^ it.b[31]) ? -q : q;
        end else begin
          rm = ma % mb;
          r.value = it.a[31] ? -rm : rm;
        end
      end
      i32alu_pkg::OP_AND: r.value = it.a & it.b;
      i32alu_pkg::OP_OR:  r.value = it.a | it.b;
      i32alu_pkg::OP_XOR: r.value = it.a ^ it.b;
      i32alu_pkg::OP_LSL: r.value = it.a << sh;
      i32alu_pkg::OP_ASR: r.value = $unsigned($signed(it.a) >>> sh);
      i32alu_pkg::OP_LSR: r.value = it.a >> sh;
      i32alu_pkg::OP_CMP: begin
        if ($signed(it.a) < $signed(it.b)) r.value = '1;
        else if ($signed(it.a) > $signed(it.b)) r.value = 32'd1;
        else r.value = '0;
      end
      default: r.value = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    num_errors++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
  endtask

  // Biased operand: corners often, random otherwise
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      4: return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  // Driver: present items at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        // item at the previous edge was taken; predictor ran in the monitor
      end
      if ((start_i && busy_o)) begin
        // hold current item
      end else if (item_q.size() > 0 && !(hold_until_drained && expected_q.size() > 0)
                   && ($urandom_range(0, 99) >= idle_pct)) begin
        alu_item_t it;
        it = item_q.pop_front();
        op_i <= it.op;
        operand_a_i <= it.a;
        operand_b_i <= it.b;
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: record accepted items, check results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", result_value_o, '0);
        end else begin
          alu_result_t want;
          want = expected_q.pop_front();
          num_checked++;
          if (result_value_o !== want.value)
            report_mismatch("result_value", result_value_o, want.value);
          if (divide_error_o !== want.dz)
            report_mismatch("divide_error", {31'd0, divide_error_o}, {31'd0, want.dz});
        end
      end
      if (start_i && !busy_o) begin
        alu_item_t it;
        alu_result_t r;
        it.op = op_i;
        it.a = operand_a_i;
        it.b = operand_b_i;
        r = alu_predict(it);
        if (r.dz) num_dz++;
        expected_q.push_back(r);
      end
    end
  end

  task automatic push_item(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    alu_item_t it;
    it.op = op;
    it.a = a;
    it.b = b;
    item_q.push_back(it);
  endtask

  task automatic wait_drained();
    while (item_q.size() > 0 || start_i || expected_q.size() > 0) @(posedge clk_i);
  endtask

  // Stimulus and end of run
  initial begin
    i32alu_pkg::op_e op;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed corners: each op at extremes, zero divisor, min / -1, shift counts
    push_item(i32alu_pkg::OP_NEG, 32'h8000_0000, '0);
    push_item(i32alu_pkg::OP_ADD, 32'h7fff_ffff, 32'd1);
    push_item(i32alu_pkg::OP_SUB, 32'h8000_0000, 32'd1);
    push_item(i32alu_pkg::OP_MUL, 32'hffff_ffff, 32'hffff_ffff);
    push_item(i32alu_pkg::OP_MUL, 32'h7fff_ffff, 32'h8000_0000);
    push_item(i32alu_pkg::OP_DIV, 32'd7, '0);
    push_item(i32alu_pkg::OP_MOD, 32'h8000_0000, '0);
    push_item(i32alu_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    push_item(i32alu_pkg::OP_MOD, 32'h8000_0000, 32'hffff_ffff);
    push_item(i32alu_pkg::OP_DIV, -32'sd7, 32'd2);
    push_item(i32alu_pkg::OP_MOD, -32'sd7, 32'd2);
    push_item(i32alu_pkg::OP_MOD, 32'd7, -32'sd2);
    push_item(i32alu_pkg::OP_AND, 32'haaaa_5555, 32'hffff_0000);
    push_item(i32alu_pkg::OP_OR, 32'haaaa_5555, 32'h5555_aaaa);
    push_item(i32alu_pkg::OP_XOR, 32'hffff_ffff, 32'h1234_5678);
    push_item(i32alu_pkg::OP_LSL, 32'h0000_0001, 32'hffff_ffff);
    push_item(i32alu_pkg::OP_ASR, 32'h8000_0000, 32'h0000_003f);
    push_item(i32alu_pkg::OP_ASR, 32'h8000_0000, 32'h0000_0020);
    push_item(i32alu_pkg::OP_LSR, 32'h8000_0000, 32'hffff_ffe1);
    push_item(i32alu_pkg::OP_CMP, 32'h8000_0000, 32'h7fff_ffff);
    push_item(i32alu_pkg::OP_CMP, 32'h7fff_ffff, 32'h8000_0000);
    push_item(i32alu_pkg::OP_CMP, 32'h1234_5678, 32'h1234_5678);
    push_item(4'd13, 32'hffff_ffff, 32'hffff_ffff);
    push_item(4'd14, 32'd1, 32'd2);
    push_item(4'd15, 32'h8000_0000, '0);
    wait_drained();

    // Random phases: no idling, sender mostly idle, mixed, then no idling with one drain
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 85 : (ph == 2) ? 34 : 0;
      for (int n = 0; n < NumRandom / 4; n++) begin
        op = i32alu_pkg::op_e'($urandom_range(0, 15));
        push_item(op, rand_operand(), ($urandom_range(0, 7) == 0) ? '0 : rand_operand());
      end
      if (ph == 3) begin
        // sender holds off once until the pipeline has emptied
        while (item_q.size() > NumRandom / 8) @(posedge clk_i);
        hold_until_drained = 1'b1;
        while (expected_q.size() > 0 || start_i) @(posedge clk_i);
        hold_until_drained = 1'b0;
      end
      wait_drained();
    end
    repeat (Latency + 4) @(posedge clk_i);

    $display("Checked %0d results over all ops, %0d with zero divisor.", num_checked, num_dz);
    if (num_errors == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (expected_q.size() > 0) $display("%0d results never arrived", expected_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("Timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
